[sv/ifuc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifuc_pkg
// Shared types, constants, rounding and saturation helpers of the IMU frame converter.
// ----------------------------------------------------------------------------
package ifuc_pkg;

	localparam int NUM_CALIB   = 4;
	localparam int SQRT_STAGES = 32;
	localparam int DIV_STAGES  = 32;
	// vector path is 4 stages, orientation path 72 stages
	localparam int VEC_DLY     = 68;

	localparam logic [1:0] REG_QX = 2'd0;
	localparam logic [1:0] REG_QY = 2'd1;
	localparam logic [1:0] REG_QZ = 2'd2;
	localparam logic [1:0] REG_QW = 2'd3;

	typedef logic signed [31:0] word_t;

	// g -> m/s^2 in Q.27, deg -> rad in Q.36
	localparam word_t GRAV_Q27 = 32'sd1316226282;
	localparam word_t D2R_Q36  = 32'sd1199381129;
	localparam logic signed [63:0] ONE_Q30 = 64'sd1073741824;
	localparam word_t ONE_Q30_W = 32'sd1073741824;

	localparam word_t CALIB_X_RST = -32'sd753327600;
	localparam word_t CALIB_Y_RST = 32'sd765087220;
	localparam word_t CALIB_Z_RST = -32'sd6350764;
	localparam word_t CALIB_W_RST = -32'sd4591084;

	// normalized quaternion lane: sign and magnitude (magnitude <= 2^30)
	typedef struct packed {
		logic             ident;
		logic [3:0]       neg;
		logic [3:0][30:0] mag;
	} qside_t;

	typedef logic [5:0][31:0] vecpk_t;

	// round half up, then >> 30
	function automatic logic signed [63:0] rshr30(input logic signed [63:0] p);
		logic signed [63:0] t;
		t = p + 64'sd536870912;
		return t >>> 30;
	endfunction

	function automatic word_t sat32(input logic signed [63:0] v);
		word_t r;
		if (v > 64'sd2147483647)
			r = 32'sh7fffffff;
		else if (v < -64'sd2147483648)
			r = 32'sh80000000;
		else
			r = signed'(v[31:0]);
		return r;
	endfunction

endpackage

[sv/imu_frame_unit_converter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_frame_unit_converter_core
// Converts one IMU sample per cycle: unit scaling and calibration rotation
// of acceleration and rate, calibrated and normalized orientation.
//
//   port group      dir   beat marked by
//   sample in       in    start (busy is always low)
//   result out      out   done, one cycle, no back-pressure
//   calib write     in    wr_en, wr_idx, wr_data
//
// One sample per cycle; results leave in the order of their start beats.
// Latency is set by the 32-stage square root and the 32-stage divider of
// the orientation path; the vectors wait in a delay line to match.
// Reset clears the pipeline valid bits and loads the default calibration.
// Nothing stalls: every accepted beat leaves as one done beat.
// ----------------------------------------------------------------------------
module imu_frame_unit_converter_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               wr_en,
	input  logic [1:0]         wr_idx,
	input  logic [31:0]        wr_data,
	input  logic signed [31:0] accel_x,
	input  logic signed [31:0] accel_y,
	input  logic signed [31:0] accel_z,
	input  logic signed [31:0] rate_x,
	input  logic signed [31:0] rate_y,
	input  logic signed [31:0] rate_z,
	input  logic signed [31:0] orient_x,
	input  logic signed [31:0] orient_y,
	input  logic signed [31:0] orient_z,
	input  logic signed [31:0] orient_w,
	output logic               done,
	output logic signed [31:0] out_accel_x,
	output logic signed [31:0] out_accel_y,
	output logic signed [31:0] out_accel_z,
	output logic signed [31:0] out_rate_x,
	output logic signed [31:0] out_rate_y,
	output logic signed [31:0] out_rate_z,
	output logic signed [31:0] out_orient_x,
	output logic signed [31:0] out_orient_y,
	output logic signed [31:0] out_orient_z,
	output logic signed [31:0] out_orient_w
);
	import ifuc_pkg::*;

	word_t  calib_q [NUM_CALIB];
	word_t  vin [6];
	word_t  orient [4];
	logic   acc;

	logic   vec_vld;
	word_t  vout [6];
	vecpk_t vd_s [1:VEC_DLY];
	vecpk_t vec_pk;

	logic        qn_vld;
	logic [62:0] ss;
	qside_t      qn_side;
	logic        sq_vld;
	logic [31:0] root;
	qside_t      sq_side;
	logic        dv_vld;
	word_t       quat [4];

	assign busy = 1'b0;
	assign acc  = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_q[REG_QX] <= CALIB_X_RST;
			calib_q[REG_QY] <= CALIB_Y_RST;
			calib_q[REG_QZ] <= CALIB_Z_RST;
			calib_q[REG_QW] <= CALIB_W_RST;
		end else if (wr_en) begin
			calib_q[wr_idx] <= signed'(wr_data);
		end
	end

	assign vin[0]    = accel_x;
	assign vin[1]    = accel_y;
	assign vin[2]    = accel_z;
	assign vin[3]    = rate_x;
	assign vin[4]    = rate_y;
	assign vin[5]    = rate_z;
	assign orient[0] = orient_x;
	assign orient[1] = orient_y;
	assign orient[2] = orient_z;
	assign orient[3] = orient_w;

	ifuc_vec_path u_vec (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (acc),
		.calib   (calib_q),
		.vin     (vin),
		.out_vld (vec_vld),
		.vout    (vout)
	);

	ifuc_quat_norm u_qnorm (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (acc),
		.calib   (calib_q),
		.orient  (orient),
		.out_vld (qn_vld),
		.sum_sq  (ss),
		.side    (qn_side)
	);

	ifuc_isqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (qn_vld),
		.rad      (ss),
		.in_side  (qn_side),
		.out_vld  (sq_vld),
		.root     (root),
		.out_side (sq_side)
	);

	ifuc_qdiv u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (sq_vld),
		.den     (root),
		.in_side (sq_side),
		.out_vld (dv_vld),
		.quat    (quat)
	);

	// vector results wait for the orientation path; only load real beats
	always_comb begin
		for (int i = 0; i < 6; i++)
			vec_pk[i] = vout[i];
	end

	always_ff @(posedge clk) begin
		if (vec_vld)
			vd_s[1] <= vec_pk;
		for (int k = 2; k <= VEC_DLY; k++)
			vd_s[k] <= vd_s[k - 1];
	end

	assign done         = dv_vld;
	assign out_accel_x  = signed'(vd_s[VEC_DLY][0]);
	assign out_accel_y  = signed'(vd_s[VEC_DLY][1]);
	assign out_accel_z  = signed'(vd_s[VEC_DLY][2]);
	assign out_rate_x   = signed'(vd_s[VEC_DLY][3]);
	assign out_rate_y   = signed'(vd_s[VEC_DLY][4]);
	assign out_rate_z   = signed'(vd_s[VEC_DLY][5]);
	assign out_orient_x = quat[0];
	assign out_orient_y = quat[1];
	assign out_orient_z = quat[2];
	assign out_orient_w = quat[3];

endmodule

[sv/ifuc_vec_path.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifuc_vec_path
// Unit scaling of acceleration and rate, and rotation by the calibration
// matrix. Four stages; the matrix is rebuilt from the calibration registers.
// ----------------------------------------------------------------------------
module ifuc_vec_path (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_vld,
	input  ifuc_pkg::word_t calib [4],
	input  ifuc_pkg::word_t vin [6],
	output logic            out_vld,
	output ifuc_pkg::word_t vout [6]
);
	import ifuc_pkg::*;

	// matrix: products, then entries (both registered, in that order, from calib)
	logic signed [63:0] mprod_q [9];
	word_t              mat_q [9];

	logic               vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [63:0] sp_s1 [6];
	word_t              sc_s2 [6];
	logic signed [63:0] rp_s3 [18];
	word_t              vo_s4 [6];

	logic signed [63:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
	logic signed [63:0] m_raw [9];

	always_comb begin
		xx = rshr30(mprod_q[0]);
		yy = rshr30(mprod_q[1]);
		zz = rshr30(mprod_q[2]);
		xy = rshr30(mprod_q[3]);
		xz = rshr30(mprod_q[4]);
		yz = rshr30(mprod_q[5]);
		wx = rshr30(mprod_q[6]);
		wy = rshr30(mprod_q[7]);
		wz = rshr30(mprod_q[8]);
		m_raw[0] = ONE_Q30 - 64'sd2 * (yy + zz);
		m_raw[1] = 64'sd2 * (xy - wz);
		m_raw[2] = 64'sd2 * (xz + wy);
		m_raw[3] = 64'sd2 * (xy + wz);
		m_raw[4] = ONE_Q30 - 64'sd2 * (xx + zz);
		m_raw[5] = 64'sd2 * (yz - wx);
		m_raw[6] = 64'sd2 * (xz - wy);
		m_raw[7] = 64'sd2 * (yz + wx);
		m_raw[8] = ONE_Q30 - 64'sd2 * (xx + yy);
	end

	always_ff @(posedge clk) begin
		mprod_q[0] <= calib[REG_QX] * calib[REG_QX];
		mprod_q[1] <= calib[REG_QY] * calib[REG_QY];
		mprod_q[2] <= calib[REG_QZ] * calib[REG_QZ];
		mprod_q[3] <= calib[REG_QX] * calib[REG_QY];
		mprod_q[4] <= calib[REG_QX] * calib[REG_QZ];
		mprod_q[5] <= calib[REG_QY] * calib[REG_QZ];
		mprod_q[6] <= calib[REG_QW] * calib[REG_QX];
		mprod_q[7] <= calib[REG_QW] * calib[REG_QY];
		mprod_q[8] <= calib[REG_QW] * calib[REG_QZ];
		for (int i = 0; i < 9; i++)
			mat_q[i] <= sat32(m_raw[i]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sp_s1[i]     <= vin[i] * GRAV_Q27;
			sp_s1[3 + i] <= vin[3 + i] * D2R_Q36;
		end
		for (int i = 0; i < 3; i++) begin
			sc_s2[i]     <= sat32((sp_s1[i] + 64'sd67108864) >>> 27);
			sc_s2[3 + i] <= sat32((sp_s1[3 + i] + 64'sd34359738368) >>> 36);
		end
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 3; k++) begin
				rp_s3[3 * r + k]     <= mat_q[3 * r + k] * sc_s2[k];
				rp_s3[9 + 3 * r + k] <= mat_q[3 * r + k] * sc_s2[3 + k];
			end
		end
		for (int r = 0; r < 6; r++)
			vo_s4[r] <= sat32(rshr30(rp_s3[3 * r]) + rshr30(rp_s3[3 * r + 1])
				+ rshr30(rp_s3[3 * r + 2]));
	end

	assign out_vld = vld_s4;
	assign vout    = vo_s4;

endmodule

[sv/ifuc_quat_norm.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifuc_quat_norm
// Hamilton product calib * orientation, common power-of-two scaling and
// sum of squares. Seven stages.
// ----------------------------------------------------------------------------
module ifuc_quat_norm (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_vld,
	input  ifuc_pkg::word_t  calib [4],
	input  ifuc_pkg::word_t  orient [4],
	output logic             out_vld,
	output logic [62:0]      sum_sq,
	output ifuc_pkg::qside_t side
);
	import ifuc_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	logic signed [63:0] pr_s1 [4][4];
	logic               ident_s1, ident_s2, ident_s3, ident_s4;
	logic signed [35:0] q_s2 [4];
	logic signed [35:0] q_s3 [4];
	logic [34:0]        amax_s3;
	logic signed [35:0] q_s4 [4];
	logic               right_s4;
	logic [4:0]         sh_s4;
	qside_t             side_s5, side_s6, side_s7;
	logic [61:0]        sq_s6 [4];
	logic [62:0]        ss_s7;

	// stage 2 sums
	logic signed [63:0] rt [4][4];
	logic signed [63:0] qsum [4];
	// stage 3
	logic [34:0]        amax_c;
	logic               qzero_c;
	// stage 4
	logic [5:0]         msb_c;
	// stage 5
	logic signed [35:0] half_c;
	logic signed [35:0] t_c [4];
	logic signed [35:0] a_c [4];

	always_comb begin
		for (int a = 0; a < 4; a++)
			for (int b = 0; b < 4; b++)
				rt[a][b] = rshr30(pr_s1[a][b]);
		// calib index a: x,y,z,w ; orientation index b: x,y,z,w
		qsum[0] = rt[3][0] + rt[0][3] + rt[1][2] - rt[2][1];
		qsum[1] = rt[3][1] - rt[0][2] + rt[1][3] + rt[2][0];
		qsum[2] = rt[3][2] + rt[0][1] - rt[1][0] + rt[2][3];
		qsum[3] = rt[3][3] - rt[0][0] - rt[1][1] - rt[2][2];
	end

	always_comb begin
		logic signed [35:0] ab;
		amax_c  = '0;
		qzero_c = 1'b1;
		for (int i = 0; i < 4; i++) begin
			ab = q_s2[i][35] ? -q_s2[i] : q_s2[i];
			if (ab[34:0] > amax_c)
				amax_c = ab[34:0];
			if (q_s2[i] != '0)
				qzero_c = 1'b0;
		end
	end

	always_comb begin
		msb_c = '0;
		for (int i = 0; i < 35; i++)
			if (amax_s3[i])
				msb_c = 6'(i);
	end

	always_comb begin
		half_c = 36'sd1 <<< (sh_s4 - 5'd1);
		for (int i = 0; i < 4; i++) begin
			if (right_s4)
				t_c[i] = (q_s4[i] + half_c) >>> sh_s4;
			else
				t_c[i] = q_s4[i] <<< sh_s4;
			a_c[i] = t_c[i][35] ? -t_c[i] : t_c[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < 4; a++)
			for (int b = 0; b < 4; b++)
				pr_s1[a][b] <= calib[a] * orient[b];
		ident_s1 <= (orient[0] == '0) && (orient[1] == '0) && (orient[2] == '0)
			&& (orient[3] == '0);

		for (int i = 0; i < 4; i++)
			q_s2[i] <= qsum[i][35:0];
		ident_s2 <= ident_s1;

		q_s3     <= q_s2;
		amax_s3  <= amax_c;
		ident_s3 <= ident_s2 | qzero_c;

		// bring the largest magnitude into [2^29, 2^30]
		q_s4     <= q_s3;
		ident_s4 <= ident_s3;
		if (msb_c >= 6'd30) begin
			right_s4 <= 1'b1;
			sh_s4    <= 5'(msb_c - 6'd29);
		end else begin
			right_s4 <= 1'b0;
			sh_s4    <= 5'(6'd29 - msb_c);
		end

		side_s5.ident <= ident_s4;
		for (int i = 0; i < 4; i++) begin
			side_s5.neg[i] <= t_c[i][35];
			side_s5.mag[i] <= a_c[i][30:0];
		end

		side_s6 <= side_s5;
		for (int i = 0; i < 4; i++)
			sq_s6[i] <= side_s5.mag[i] * side_s5.mag[i];

		side_s7 <= side_s6;
		ss_s7   <= {1'b0, sq_s6[0]} + {1'b0, sq_s6[1]} + {1'b0, sq_s6[2]}
			+ {1'b0, sq_s6[3]};
	end

	assign out_vld = vld_s7;
	assign sum_sq  = ss_s7;
	assign side    = side_s7;

endmodule

[sv/ifuc_isqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifuc_isqrt
// Floor square root, one result bit per stage, with side data carried along.
// ----------------------------------------------------------------------------
module ifuc_isqrt (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_vld,
	input  logic [62:0]      rad,
	input  ifuc_pkg::qside_t in_side,
	output logic             out_vld,
	output logic [31:0]      root,
	output ifuc_pkg::qside_t out_side
);
	import ifuc_pkg::*;

	logic        vld_s  [1:SQRT_STAGES];
	logic [63:0] rad_s  [1:SQRT_STAGES];
	logic [33:0] rem_s  [1:SQRT_STAGES];
	logic [31:0] root_s [1:SQRT_STAGES];
	qside_t      side_s [1:SQRT_STAGES];

	logic        p_vld  [SQRT_STAGES];
	logic [63:0] p_rad  [SQRT_STAGES];
	logic [33:0] p_rem  [SQRT_STAGES];
	logic [31:0] p_root [SQRT_STAGES];
	qside_t      p_side [SQRT_STAGES];

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
		logic [35:0] cur;
		logic [35:0] trial;

		if (k == 0) begin : g_first
			assign p_vld[k]  = in_vld;
			assign p_rad[k]  = {1'b0, rad};
			assign p_rem[k]  = '0;
			assign p_root[k] = '0;
			assign p_side[k] = in_side;
		end else begin : g_next
			assign p_vld[k]  = vld_s[k];
			assign p_rad[k]  = rad_s[k];
			assign p_rem[k]  = rem_s[k];
			assign p_root[k] = root_s[k];
			assign p_side[k] = side_s[k];
		end

		assign cur   = {p_rem[k], p_rad[k][63:62]};
		assign trial = {2'b00, p_root[k], 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k + 1] <= 1'b0;
			else
				vld_s[k + 1] <= p_vld[k];
		end

		always_ff @(posedge clk) begin
			rad_s[k + 1]  <= {p_rad[k][61:0], 2'b00};
			side_s[k + 1] <= p_side[k];
			if (cur >= trial) begin
				rem_s[k + 1]  <= 34'(cur - trial);
				root_s[k + 1] <= {p_root[k][30:0], 1'b1};
			end else begin
				rem_s[k + 1]  <= cur[33:0];
				root_s[k + 1] <= {p_root[k][30:0], 1'b0};
			end
		end
	end

	assign out_vld  = vld_s[SQRT_STAGES];
	assign root     = root_s[SQRT_STAGES];
	assign out_side = side_s[SQRT_STAGES];

endmodule

[sv/ifuc_qdiv.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifuc_qdiv
// Four-lane restoring divider: round(c * 2^30 / n), half away from zero,
// one quotient bit per stage, then sign, saturation and identity select.
// ----------------------------------------------------------------------------
module ifuc_qdiv (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_vld,
	input  logic [31:0]      den,
	input  ifuc_pkg::qside_t in_side,
	output logic             out_vld,
	output ifuc_pkg::word_t  quat [4]
);
	import ifuc_pkg::*;

	logic             vld_s  [1:DIV_STAGES];
	logic [31:0]      den_s  [1:DIV_STAGES];
	logic [3:0][31:0] rem_s  [1:DIV_STAGES];
	logic [3:0][31:0] low_s  [1:DIV_STAGES];
	logic [3:0][31:0] quo_s  [1:DIV_STAGES];
	logic [4:0]       flag_s [1:DIV_STAGES];

	logic             p_vld  [DIV_STAGES];
	logic [31:0]      p_den  [DIV_STAGES];
	logic [3:0][31:0] p_rem  [DIV_STAGES];
	logic [3:0][31:0] p_low  [DIV_STAGES];
	logic [3:0][31:0] p_quo  [DIV_STAGES];
	logic [4:0]       p_flag [DIV_STAGES];

	logic [3:0][61:0] num;
	logic             vld_out_q;
	word_t            quat_q [4];

	// numerator carries the rounding half of the divisor
	always_comb begin
		for (int l = 0; l < 4; l++)
			num[l] = {1'b0, in_side.mag[l], 30'b0} + {31'b0, den[31:1]};
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		if (k == 0) begin : g_first
			assign p_vld[k]  = in_vld;
			assign p_den[k]  = den;
			assign p_flag[k] = {in_side.ident, in_side.neg};
			assign p_quo[k]  = '0;
			for (genvar l = 0; l < 4; l++) begin : g_lane
				assign p_rem[k][l] = {2'b00, num[l][61:32]};
				assign p_low[k][l] = num[l][31:0];
			end
		end else begin : g_next
			assign p_vld[k]  = vld_s[k];
			assign p_den[k]  = den_s[k];
			assign p_flag[k] = flag_s[k];
			assign p_quo[k]  = quo_s[k];
			assign p_rem[k]  = rem_s[k];
			assign p_low[k]  = low_s[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k + 1] <= 1'b0;
			else
				vld_s[k + 1] <= p_vld[k];
		end

		always_ff @(posedge clk) begin
			logic [32:0] r2;
			den_s[k + 1]  <= p_den[k];
			flag_s[k + 1] <= p_flag[k];
			for (int l = 0; l < 4; l++) begin
				r2 = {p_rem[k][l], p_low[k][l][31]};
				low_s[k + 1][l] <= {p_low[k][l][30:0], 1'b0};
				if (r2 >= {1'b0, p_den[k]}) begin
					rem_s[k + 1][l] <= 32'(r2 - {1'b0, p_den[k]});
					quo_s[k + 1][l] <= {p_quo[k][l][30:0], 1'b1};
				end else begin
					rem_s[k + 1][l] <= r2[31:0];
					quo_s[k + 1][l] <= {p_quo[k][l][30:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_out_q <= 1'b0;
		else
			vld_out_q <= vld_s[DIV_STAGES];
	end

	always_ff @(posedge clk) begin
		logic signed [63:0] qv;
		for (int l = 0; l < 4; l++) begin
			qv = signed'({32'b0, quo_s[DIV_STAGES][l]});
			if (flag_s[DIV_STAGES][4])
				quat_q[l] <= (l == 3) ? ONE_Q30_W : '0;
			else if (flag_s[DIV_STAGES][l])
				quat_q[l] <= sat32(-qv);
			else
				quat_q[l] <= sat32(qv);
		end
	end

	assign out_vld = vld_out_q;
	assign quat    = quat_q;

endmodule
